/* rtl/rmd_pkg.sv */
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared widths, the initial vector, round tables and round functions of the
// RIPEMD-160 hash.
// ----------------------------------------------------------------------------
package rmd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 61;
  localparam int unsigned Rounds = 80;

  typedef logic [WordW-1:0] word_t;

  localparam word_t Iv0 = 32'h67452301;
  localparam word_t Iv1 = 32'hEFCDAB89;
  localparam word_t Iv2 = 32'h98BADCFE;
  localparam word_t Iv3 = 32'h10325476;
  localparam word_t Iv4 = 32'hC3D2E1F0;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [3:0] SelA [Rounds] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
  };

  localparam logic [3:0] SelB [Rounds] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
  };

  localparam logic [4:0] SftA [Rounds] = '{
    5'd11, 5'd14, 5'd15, 5'd12, 5'd5, 5'd8, 5'd7, 5'd9,
    5'd11, 5'd13, 5'd14, 5'd15, 5'd6, 5'd7, 5'd9, 5'd8,
    5'd7, 5'd6, 5'd8, 5'd13, 5'd11, 5'd9, 5'd7, 5'd15,
    5'd7, 5'd12, 5'd15, 5'd9, 5'd11, 5'd7, 5'd13, 5'd12,
    5'd11, 5'd13, 5'd6, 5'd7, 5'd14, 5'd9, 5'd13, 5'd15,
    5'd14, 5'd8, 5'd13, 5'd6, 5'd5, 5'd12, 5'd7, 5'd5,
    5'd11, 5'd12, 5'd14, 5'd15, 5'd14, 5'd15, 5'd9, 5'd8,
    5'd9, 5'd14, 5'd5, 5'd6, 5'd8, 5'd6, 5'd5, 5'd12,
    5'd9, 5'd15, 5'd5, 5'd11, 5'd6, 5'd8, 5'd13, 5'd12,
    5'd5, 5'd12, 5'd13, 5'd14, 5'd11, 5'd8, 5'd5, 5'd6
  };

  localparam logic [4:0] SftB [Rounds] = '{
    5'd8, 5'd9, 5'd9, 5'd11, 5'd13, 5'd15, 5'd15, 5'd5,
    5'd7, 5'd7, 5'd8, 5'd11, 5'd14, 5'd14, 5'd12, 5'd6,
    5'd9, 5'd13, 5'd15, 5'd7, 5'd12, 5'd8, 5'd9, 5'd11,
    5'd7, 5'd7, 5'd12, 5'd7, 5'd6, 5'd15, 5'd13, 5'd11,
    5'd9, 5'd7, 5'd15, 5'd11, 5'd8, 5'd6, 5'd6, 5'd14,
    5'd12, 5'd13, 5'd5, 5'd14, 5'd13, 5'd13, 5'd7, 5'd5,
    5'd15, 5'd5, 5'd8, 5'd11, 5'd14, 5'd14, 5'd6, 5'd14,
    5'd6, 5'd9, 5'd12, 5'd9, 5'd12, 5'd5, 5'd15, 5'd8,
    5'd8, 5'd5, 5'd12, 5'd9, 5'd12, 5'd5, 5'd14, 5'd6,
    5'd8, 5'd13, 5'd6, 5'd5, 5'd15, 5'd13, 5'd11, 5'd11
  };

  function automatic word_t rotl(input word_t v, input logic [4:0] s);
    logic [2*WordW-1:0] w;
    w = {v, v} << s;
    return w[2*WordW-1:WordW];
  endfunction

  function automatic word_t mix(input logic [2:0] g, input word_t x, input word_t y,
                                input word_t z);
    word_t r;
    case (g)
      3'd0:    r = x ^ y ^ z;
      3'd1:    r = (x & y) | (~x & z);
      3'd2:    r = (x | ~y) ^ z;
      3'd3:    r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

  function automatic word_t add_left(input logic [2:0] g);
    word_t r;
    case (g)
      3'd0:    r = 32'h00000000;
      3'd1:    r = 32'h5A827999;
      3'd2:    r = 32'h6ED9EBA1;
      3'd3:    r = 32'h8F1BBCDC;
      default: r = 32'hA953FD4E;
    endcase
    return r;
  endfunction

  function automatic word_t add_right(input logic [2:0] g);
    word_t r;
    case (g)
      3'd0:    r = 32'h50A28BE6;
      3'd1:    r = 32'h5C4DD124;
      3'd2:    r = 32'h6D703EF3;
      3'd3:    r = 32'h7A6D76E9;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

/* rtl/rmd_if.sv */
// ----------------------------------------------------------------------------
// rmd_if
// Valid/ready channels of the RIPEMD-160 hash: message bytes in, digest
// words out.
// ----------------------------------------------------------------------------
interface rmd_in_if;
  logic                     valid;
  logic                     ready;
  logic [rmd_pkg::ByteW-1:0] data_byte;
  logic                     byte_valid;
  logic                     end_of_message;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_message, output ready);
endinterface

interface rmd_out_if;
  logic                     valid;
  logic                     ready;
  logic [rmd_pkg::WordW-1:0] digest_word;
  logic                     final_word;

  modport source (output valid, output digest_word, output final_word, input ready);
  modport sink   (input valid, input digest_word, input final_word, output ready);
endinterface

/* rtl/ripemd160_hash.sv */
// ----------------------------------------------------------------------------
// ripemd160_hash
// Streaming RIPEMD-160: bytes in, five chaining words out per message.
// ----------------------------------------------------------------------------
// Each accepted word carries at most one message byte; plain bytes are taken
// back to back while the block is idle. Every 64th byte starts a compression
// (a read setup step, 80 rounds with both lines stepping together, a fold
// into the chaining value), during which no word is accepted. The message
// block sits in a 16-entry memory with two registered read ports that feed
// the two lines in each round. An end-of-message word costs a padding step,
// up to 15 words of zero and length fill and one compression; when the
// length does not fit behind the pad byte, at most one fill word and a
// compression close the block, then a second block takes 16 fill words and
// another compression. Five digest words h0..h4 follow, one per cycle as the
// sink takes them. The byte count wraps modulo 2^61, so the bit length wraps
// modulo 2^64.
module ripemd160_hash (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmd_in_if.sink    in_i,
  rmd_out_if.source out_o
);
  import rmd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_FILL, S_LOAD, S_ROUND, S_FINISH, S_OUT
  } state_e;

  typedef logic [4:0][WordW-1:0] line_t;

  state_e            state_q, state_d;
  line_t             chain_q, chain_d;
  line_t             lft_q, lft_d, rgt_q, rgt_d;
  logic [CountW-1:0] count_q, count_d;
  logic [23:0]       acc_q, acc_d;
  logic [3:0]        fill_q, fill_d;
  logic [6:0]        rnd_q, rnd_d;
  logic [2:0]        out_idx_q, out_idx_d;
  logic              len_phase_q, len_phase_d;
  logic              len_pend_q, len_pend_d;
  logic              pad_pend_q, pad_pend_d;
  logic              final_q, final_d;

  word_t             blk_mem_q [16];
  word_t             rd_a_q, rd_b_q;
  logic              mem_we;
  logic [3:0]        mem_waddr, raddr_a, raddr_b;
  word_t             mem_wdata;

  logic [5:0]        pos;
  logic [1:0]        lane;
  logic              in_fire, out_fire;
  logic [6:0]        rnd_next;
  logic [2:0]        grp;
  word_t             sum_a, sum_b, t_a, t_b;

  assign pos      = count_q[5:0];
  assign lane     = pos[1:0];
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign rnd_next = (rnd_q == 7'(Rounds - 1)) ? 7'd0 : rnd_q + 7'd1;
  assign grp      = rnd_q[6:4];

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = chain_q[out_idx_q];
  assign out_o.final_word  = (out_idx_q == 3'd4);

  // Both lines of one round.
  always_comb begin
    sum_a = lft_q[0] + mix(grp, lft_q[1], lft_q[2], lft_q[3]) + rd_a_q + add_left(grp);
    t_a   = rotl(sum_a, SftA[rnd_q]) + lft_q[4];
    sum_b = rgt_q[0] + mix(3'd4 - grp, rgt_q[1], rgt_q[2], rgt_q[3]) + rd_b_q
            + add_right(grp);
    t_b   = rotl(sum_b, SftB[rnd_q]) + rgt_q[4];
  end

  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    lft_d       = lft_q;
    rgt_d       = rgt_q;
    count_d     = count_q;
    acc_d       = acc_q;
    fill_d      = fill_q;
    rnd_d       = rnd_q;
    out_idx_d   = out_idx_q;
    len_phase_d = len_phase_q;
    len_pend_d  = len_pend_q;
    pad_pend_d  = pad_pend_q;
    final_d     = final_q;
    mem_we      = 1'b0;
    mem_waddr   = pos[5:2];
    mem_wdata   = '0;
    raddr_a     = SelA[rnd_next];
    raddr_b     = SelB[rnd_next];

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.byte_valid) begin
            case (lane)
              2'd0:    acc_d[7:0]   = in_i.data_byte;
              2'd1:    acc_d[15:8]  = in_i.data_byte;
              2'd2:    acc_d[23:16] = in_i.data_byte;
              default: begin
                mem_we    = 1'b1;
                mem_wdata = {in_i.data_byte, acc_q};
              end
            endcase
            count_d = count_q + CountW'(1);
            if (pos == 6'd63) begin
              state_d    = S_LOAD;
              pad_pend_d = in_i.end_of_message;
              final_d    = 1'b0;
              len_pend_d = 1'b0;
            end else if (in_i.end_of_message) begin
              state_d = S_PAD;
            end
          end else if (in_i.end_of_message) begin
            state_d = S_PAD;
          end
        end
      end

      S_PAD: begin
        // Close the open word with the pad byte, keep the bytes below it.
        mem_we = 1'b1;
        case (lane)
          2'd0:    mem_wdata = {24'd0, PadByte};
          2'd1:    mem_wdata = {16'd0, PadByte, acc_q[7:0]};
          2'd2:    mem_wdata = {8'd0, PadByte, acc_q[15:0]};
          default: mem_wdata = {PadByte, acc_q};
        endcase
        final_d     = 1'b0;
        len_phase_d = (pos[5:3] != 3'd7);
        len_pend_d  = (pos[5:3] == 3'd7);
        if (pos[5:2] == 4'd15) begin
          state_d = S_LOAD;
        end else begin
          fill_d  = pos[5:2] + 4'd1;
          state_d = S_FILL;
        end
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_q;
        if (len_phase_q && fill_q == 4'd14) begin
          mem_wdata = {count_q[28:0], 3'b000};
        end else if (len_phase_q && fill_q == 4'd15) begin
          mem_wdata = count_q[60:29];
        end
        if (fill_q == 4'd15) begin
          state_d = S_LOAD;
          final_d = len_phase_q;
        end else begin
          fill_d = fill_q + 4'd1;
        end
      end

      S_LOAD: begin
        raddr_a = SelA[0];
        raddr_b = SelB[0];
        lft_d   = chain_q;
        rgt_d   = chain_q;
        rnd_d   = 7'd0;
        state_d = S_ROUND;
      end

      S_ROUND: begin
        lft_d[0] = lft_q[4];
        lft_d[4] = lft_q[3];
        lft_d[3] = rotl(lft_q[2], 5'd10);
        lft_d[2] = lft_q[1];
        lft_d[1] = t_a;
        rgt_d[0] = rgt_q[4];
        rgt_d[4] = rgt_q[3];
        rgt_d[3] = rotl(rgt_q[2], 5'd10);
        rgt_d[2] = rgt_q[1];
        rgt_d[1] = t_b;
        rnd_d    = rnd_next;
        if (rnd_q == 7'(Rounds - 1)) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        chain_d[0] = chain_q[1] + lft_q[2] + rgt_q[3];
        chain_d[1] = chain_q[2] + lft_q[3] + rgt_q[4];
        chain_d[2] = chain_q[3] + lft_q[4] + rgt_q[0];
        chain_d[3] = chain_q[4] + lft_q[0] + rgt_q[1];
        chain_d[4] = chain_q[0] + lft_q[1] + rgt_q[2];
        if (final_q) begin
          out_idx_d = 3'd0;
          final_d   = 1'b0;
          state_d   = S_OUT;
        end else if (len_pend_q) begin
          // Second block of the padding: zeros, then the length.
          fill_d      = 4'd0;
          len_phase_d = 1'b1;
          len_pend_d  = 1'b0;
          state_d     = S_FILL;
        end else if (pad_pend_q) begin
          pad_pend_d = 1'b0;
          state_d    = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_OUT: begin
        if (out_fire) begin
          if (out_idx_q == 3'd4) begin
            chain_d = {Iv4, Iv3, Iv2, Iv1, Iv0};
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            out_idx_d = out_idx_q + 3'd1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chain_q     <= {Iv4, Iv3, Iv2, Iv1, Iv0};
      count_q     <= '0;
      fill_q      <= '0;
      rnd_q       <= '0;
      out_idx_q   <= '0;
      len_phase_q <= 1'b0;
      len_pend_q  <= 1'b0;
      pad_pend_q  <= 1'b0;
      final_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      rnd_q       <= rnd_d;
      out_idx_q   <= out_idx_d;
      len_phase_q <= len_phase_d;
      len_pend_q  <= len_pend_d;
      pad_pend_q  <= pad_pend_d;
      final_q     <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lft_q <= lft_d;
    rgt_q <= rgt_d;
    acc_q <= acc_d;
  end

  // Message block memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blk_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= blk_mem_q[raddr_a];
    rd_b_q <= blk_mem_q[raddr_b];
  end

  a_no_input_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input accepted while digest words are pending");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (rnd_q < 7'(Rounds)))
    else $error("round counter out of range");

  a_last_round_folds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == 7'(Rounds - 1)) |=> (state_q == S_FINISH))
    else $error("compression did not fold after the last round");

  a_reinit_after_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_idx_q == 3'd4) |=> (chain_q[0] == Iv0 && chain_q[4] == Iv4
                                         && count_q == '0 && state_q == S_IDLE))
    else $error("chaining value not reinitialized after the digest");

  a_load_before_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |=> (state_q == S_ROUND && rnd_q == 7'd0))
    else $error("rounds did not start at round zero");

endmodule

/* tb/rmd_digest_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_digest_checker
// Watches the byte and digest channels of the RIPEMD-160 hash, keeps its own
// model of the chaining value and message block, and checks every digest
// word against the words owed for the messages closed so far.
// ----------------------------------------------------------------------------
module rmd_digest_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmd_in_if         in_mon_i,
  rmd_out_if        out_mon_i,
  output int        mismatches_o,
  output int        words_owed_o
);

  typedef struct {
    rmd_pkg::word_t value;
    logic           last;
  } digest_word_t;

  localparam rmd_pkg::word_t InitVec [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam rmd_pkg::word_t KLeft  [5] = '{
    32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
  };
  localparam rmd_pkg::word_t KRight [5] = '{
    32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
  };

  // One nibble per round, round 0 in the top nibble.
  localparam logic [319:0] PickLeft = {
    64'h0123456789ABCDEF, 64'h74D1A6F3C0952EB8, 64'h3AE49F812706DB5C,
    64'h19BA08C4D37FE562, 64'h40597C2AE138B6FD
  };
  localparam logic [319:0] PickRight = {
    64'h5E7092B4D6F81A3C, 64'h6B370D5AEF8C4912, 64'hF5137E69B8C2A04D,
    64'h86413BF05C2D97AE, 64'hCFA4158762DE039B
  };
  localparam logic [319:0] RotLeft = {
    64'hBEFC5879BDEF6798, 64'h768DB97F7CF9B7DC, 64'hBD67E9DFE8D65C75,
    64'hBCEFEF989E56865C, 64'h9F5B68DC5CDEB856
  };
  localparam logic [319:0] RotRight = {
    64'h899BDFF5778BEEC6, 64'h9DF7C89B77C76FDB, 64'h97FB866ECD5EDD75,
    64'hF58BEE6E69C9C5F8, 64'h85C9C5E68D65FDBB
  };

  rmd_pkg::word_t  chain [5];
  rmd_pkg::word_t  blk   [16];
  logic [60:0]     nbytes;
  digest_word_t    owed_words [$];
  digest_word_t    due;
  int              mismatch_cnt = 0;

  function automatic int unsigned nib(input logic [319:0] tbl, input int unsigned k);
    return int'(tbl[319 - 4*k -: 4]);
  endfunction

  // Shift amounts here are never zero.
  function automatic rmd_pkg::word_t rol(input rmd_pkg::word_t v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic rmd_pkg::word_t boolf(input int unsigned g, input rmd_pkg::word_t x,
                                           input rmd_pkg::word_t y, input rmd_pkg::word_t z);
    case (g)
      0:       return x ^ y ^ z;
      1:       return (x & y) | (~x & z);
      2:       return (x | ~y) ^ z;
      3:       return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  function automatic void fold_block();
    rmd_pkg::word_t al, bl, cl, dl, el, ar, br, cr, dr, er, t;
    int unsigned g;
    al = chain[0]; bl = chain[1]; cl = chain[2]; dl = chain[3]; el = chain[4];
    ar = al; br = bl; cr = cl; dr = dl; er = el;
    for (int unsigned k = 0; k < 80; k++) begin
      g = k / 16;
      t = rol(al + boolf(g, bl, cl, dl) + blk[nib(PickLeft, k)] + KLeft[g],
              nib(RotLeft, k)) + el;
      al = el; el = dl; dl = rol(cl, 10); cl = bl; bl = t;
      t = rol(ar + boolf(4 - g, br, cr, dr) + blk[nib(PickRight, k)] + KRight[g],
              nib(RotRight, k)) + er;
      ar = er; er = dr; dr = rol(cr, 10); cr = br; br = t;
    end
    t        = chain[1] + cl + dr;
    chain[1] = chain[2] + dl + er;
    chain[2] = chain[3] + el + ar;
    chain[3] = chain[4] + al + br;
    chain[4] = chain[0] + bl + cr;
    chain[0] = t;
  endfunction

  // Lane 0 starts a fresh word, so the upper lanes are known zero.
  function automatic void lay_byte(input int unsigned pos, input logic [7:0] b);
    if (pos % 4 == 0) begin
      blk[pos / 4] = {24'h0, b};
    end else begin
      blk[pos / 4][8 * (pos % 4) +: 8] = b;
    end
  endfunction

  function automatic void absorb_item(input logic [7:0] d, input logic bv, input logic eom);
    int unsigned pos;
    logic [63:0] bitlen;
    if (bv) begin
      pos = 32'(nbytes[5:0]);
      lay_byte(pos, d);
      nbytes = nbytes + 61'd1;
      if (pos == 63) begin
        fold_block();
      end
    end
    if (eom) begin
      pos = 32'(nbytes[5:0]);
      lay_byte(pos, 8'h80);
      for (int unsigned w = pos / 4 + 1; w < 16; w++) blk[w] = '0;
      // No room for the length: close this block and pad a fresh one.
      if (pos >= 56) begin
        fold_block();
        for (int w = 0; w < 16; w++) blk[w] = '0;
      end
      bitlen  = {nbytes, 3'b000};
      blk[14] = bitlen[31:0];
      blk[15] = bitlen[63:32];
      fold_block();
      for (int i = 0; i < 5; i++) owed_words.push_back('{chain[i], i == 4});
      chain  = InitVec;
      nbytes = '0;
    end
  endfunction

  task automatic note_mismatch(input string what);
    $display("%0t digest mismatch: %s", $time, what);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain = InitVec;
      nbytes = '0;
      owed_words.delete();
      words_owed_o <= 0;
      mismatches_o <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (owed_words.size() == 0) begin
          note_mismatch($sformatf("word %08h with none owed", out_mon_i.digest_word));
        end else begin
          due = owed_words.pop_front();
          if (out_mon_i.digest_word !== due.value)
            note_mismatch($sformatf("digest_word %08h, want %08h",
                                    out_mon_i.digest_word, due.value));
          if (out_mon_i.final_word !== due.last)
            note_mismatch($sformatf("final_word %b, want %b",
                                    out_mon_i.final_word, due.last));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        absorb_item(in_mon_i.data_byte, in_mon_i.byte_valid, in_mon_i.end_of_message);
      end
      words_owed_o <= owed_words.size();
      mismatches_o <= mismatch_cnt;
    end
  end

endmodule

/* tb/tb_ripemd160_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ripemd160_hash
// Feeds the RIPEMD-160 hash short directed messages and then random messages,
// many around the padding boundaries, with bursty input and a stalling digest
// sink; the checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_ripemd160_hash;

  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 200;
  localparam int ItemTarget = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic sink_rdy = 1'b0;
  int   mismatches;
  int   words_owed;
  int   burst_left = 0;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;
  logic [7:0] rx_tick = '0;

  rmd_in_if  in_ch ();
  rmd_out_if out_ch ();

  assign out_ch.ready = sink_rdy;

  ripemd160_hash dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  rmd_digest_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .mismatches_o (mismatches),
    .words_owed_o (words_owed)
  );

  always #5ns clk_i = ~clk_i;

  // Digest sink: stall in random spells; no new spell starts in one window of four.
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 8'd1;
    if (stall_left != 0) begin
      sink_rdy   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sink_rdy <= 1'b1;
      if (rx_tick[7:6] != 2'b00 && $urandom_range(0, 3) == 0) begin
        stall_left <= $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one word and hold it until taken; open a new burst when due.
  task automatic send_item(input logic [7:0] d, input logic bv, input logic eom);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= d;
    in_ch.byte_valid     <= bv;
    in_ch.end_of_message <= eom;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Hold off the sender until the checker owes no digest words.
  task automatic wait_for_digests();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (words_owed != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input int len, input bit close_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1, close_on_byte && i == len - 1);
    end
    if (!close_on_byte || len == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // Mostly short messages, many around the 55/56/63/64-byte padding edges.
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 8);
    if (r < 8) return $urandom_range(52, 66);
    if (r == 8) return $urandom_range(9, 51);
    return $urandom_range(67, 140);
  endfunction

  initial begin
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= '0;
    in_ch.byte_valid     <= 1'b0;
    in_ch.end_of_message <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty message, with junk on the unused byte.
    send_item(8'hFF, 1'b0, 1'b1);
    // Idle word, then single bytes closed by the end mark, then a three-byte message.
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Idle words between bytes, closed by an empty end word.
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    wait_for_digests();

    while (items_sent < ItemTarget) begin
      send_message(pick_length(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) begin
        wait_for_digests();
      end
    end
    wait_for_digests();
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rmd_pkg.sv
rtl/rmd_if.sv
rtl/ripemd160_hash.sv
tb/rmd_digest_checker.sv
tb/tb_ripemd160_hash.sv
